/* hw/rtl/two_stage_rejecting_averager_assert.svh */
// Assertion macros for the two-stage rejecting averager.
// Every macro expects a clock named clk in scope; all but TSRA_ASSERT_NEXT also expect a reset named rst.
`ifndef TWO_STAGE_REJECTING_AVERAGER_ASSERT_SVH
`define TWO_STAGE_REJECTING_AVERAGER_ASSERT_SVH

// The expression must never hold outside reset.
`define TSRA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

// Outside reset, the antecedent implies the consequent in the same cycle.
`define TSRA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// The antecedent implies the consequent in the next cycle, reset included.
`define TSRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/tsra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsra_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 23;
  localparam int COUNT_W     = 8;
  localparam int VALUE_W     = 15;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  localparam logic [SAMPLE_W-1:0] REJECT_LIMIT = 16'd32767;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 8'd10;

  // Configuration register indexes.
  localparam logic REG_INNER_COUNT = 1'b0;
  localparam logic REG_OUTER_COUNT = 1'b1;

  // One finished inner group, handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] kept;
  } group_t;

  // Start request for the shared serial divider.
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INNER_DIV,
    B_OUTER_UPD,
    B_OUTER_DIV,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/tsra_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsra_queue #(
  parameter int DEPTH = tsra_pkg::QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  tsra_pkg::group_t push_entry,
  input  wire              pop,
  output tsra_pkg::group_t head,
  output logic             not_empty,
  output logic             not_full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsra_pkg::group_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head      = entries[rd_ptr];
  assign not_empty = (fill != '0);
  assign not_full  = (fill != CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tsra_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsra_front (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [tsra_pkg::SAMPLE_W-1:0]   sample,
  input  wire [tsra_pkg::COUNT_W-1:0]    inner_count,
  input  wire                            q_not_full,
  output logic                           push,
  output tsra_pkg::group_t               push_entry
);

  logic [tsra_pkg::SUM_W-1:0]   inner_sum;
  logic [tsra_pkg::COUNT_W-1:0] inner_kept;
  logic [tsra_pkg::COUNT_W-1:0] inner_seen;

  logic                         accept;
  logic                         keep;
  logic [tsra_pkg::SUM_W-1:0]   sum_next;
  logic [tsra_pkg::COUNT_W-1:0] kept_next;
  logic [tsra_pkg::COUNT_W-1:0] seen_next;
  logic                         group_done;

  // Room in the queue is enough to take a sample, since each sample
  // pushes at most one group.
  assign in_ready = q_not_full;
  assign accept   = in_valid && q_not_full;

  assign keep       = (sample < tsra_pkg::REJECT_LIMIT);
  assign sum_next   = keep ? inner_sum + tsra_pkg::SUM_W'(sample) : inner_sum;
  assign kept_next  = keep ? inner_kept + 1'b1 : inner_kept;
  assign seen_next  = inner_seen + 1'b1;
  assign group_done = !(seen_next < inner_count);

  assign push            = accept && group_done;
  assign push_entry.sum  = sum_next;
  assign push_entry.kept = kept_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_sum  <= '0;
      inner_kept <= '0;
      inner_seen <= '0;
    end else if (accept) begin
      if (group_done) begin
        inner_sum  <= '0;
        inner_kept <= '0;
        inner_seen <= '0;
      end else begin
        inner_sum  <= sum_next;
        inner_kept <= kept_next;
        inner_seen <= seen_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tsra_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsra_div (
  input  wire                          clk,
  input  wire                          rst,
  input  tsra_pkg::div_req_t           req,
  output logic                         done,
  output logic [tsra_pkg::SUM_W-1:0]   quotient
);

  logic                           busy;
  logic [tsra_pkg::DIV_CNT_W-1:0] step;
  logic [tsra_pkg::COUNT_W-1:0]   divisor;
  logic [tsra_pkg::COUNT_W-1:0]   rem;
  logic [tsra_pkg::SUM_W-1:0]     quo;

  logic [tsra_pkg::COUNT_W:0]     rem_sh;
  logic [tsra_pkg::COUNT_W:0]     diff;
  logic                           fits;

  // Restoring division, one quotient bit per cycle. The remainder stays
  // below the divisor, so it fits in the divisor's width.
  assign rem_sh   = {rem, quo[tsra_pkg::SUM_W-1]};
  assign diff     = rem_sh - {1'b0, divisor};
  assign fits     = (rem_sh >= {1'b0, divisor});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      rem <= fits ? diff[tsra_pkg::COUNT_W-1:0] : rem_sh[tsra_pkg::COUNT_W-1:0];
      quo <= {quo[tsra_pkg::SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == tsra_pkg::DIV_CNT_W'(tsra_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tsra_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsra_back (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [tsra_pkg::COUNT_W-1:0]   outer_count,
  input  tsra_pkg::group_t              q_head,
  input  wire                           q_not_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [tsra_pkg::VALUE_W-1:0]  filtered_value,
  output logic                          no_valid_data
);

  tsra_pkg::back_state_t state, state_next;

  logic [tsra_pkg::VALUE_W-1:0] mean, mean_next;
  logic [tsra_pkg::SUM_W-1:0]   outer_sum, outer_sum_next;
  logic [tsra_pkg::COUNT_W-1:0] outer_kept, outer_kept_next;
  logic [tsra_pkg::COUNT_W-1:0] outer_seen, outer_seen_next;
  logic [tsra_pkg::VALUE_W-1:0] res_value, res_value_next;
  logic                         res_flag, res_flag_next;
  logic                         load_out;

  logic [tsra_pkg::SUM_W-1:0]   sum_new;
  logic [tsra_pkg::COUNT_W-1:0] kept_new;
  logic [tsra_pkg::COUNT_W-1:0] seen_inc;

  tsra_pkg::div_req_t           div_req;
  logic                         div_done;
  logic [tsra_pkg::SUM_W-1:0]   div_quo;

  tsra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign seen_inc = outer_seen + 1'b1;
  assign sum_new  = (mean != '0) ? outer_sum + tsra_pkg::SUM_W'(mean) : outer_sum;
  assign kept_new = (mean != '0) ? outer_kept + 1'b1 : outer_kept;

  always_comb begin
    state_next      = state;
    mean_next       = mean;
    outer_sum_next  = outer_sum;
    outer_kept_next = outer_kept;
    outer_seen_next = outer_seen;
    res_value_next  = res_value;
    res_flag_next   = res_flag;
    q_pop           = 1'b0;
    load_out        = 1'b0;
    div_req         = '0;
    unique case (state)
      tsra_pkg::B_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_head.kept != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = q_head.sum;
            div_req.divisor  = q_head.kept;
            state_next       = tsra_pkg::B_INNER_DIV;
          end else begin
            mean_next  = '0;
            state_next = tsra_pkg::B_OUTER_UPD;
          end
        end
      end
      tsra_pkg::B_INNER_DIV: begin
        if (div_done) begin
          mean_next  = div_quo[tsra_pkg::VALUE_W-1:0];
          state_next = tsra_pkg::B_OUTER_UPD;
        end
      end
      tsra_pkg::B_OUTER_UPD: begin
        if (seen_inc < outer_count) begin
          outer_sum_next  = sum_new;
          outer_kept_next = kept_new;
          outer_seen_next = seen_inc;
          state_next      = tsra_pkg::B_IDLE;
        end else begin
          outer_sum_next  = '0;
          outer_kept_next = '0;
          outer_seen_next = '0;
          if (kept_new != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_new;
            div_req.divisor  = kept_new;
            state_next       = tsra_pkg::B_OUTER_DIV;
          end else begin
            res_value_next = '0;
            res_flag_next  = 1'b1;
            state_next     = tsra_pkg::B_EMIT;
          end
        end
      end
      tsra_pkg::B_OUTER_DIV: begin
        if (div_done) begin
          res_value_next = div_quo[tsra_pkg::VALUE_W-1:0];
          res_flag_next  = 1'b0;
          state_next     = tsra_pkg::B_EMIT;
        end
      end
      tsra_pkg::B_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = tsra_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = tsra_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tsra_pkg::B_IDLE;
      outer_sum  <= '0;
      outer_kept <= '0;
      outer_seen <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      outer_sum  <= outer_sum_next;
      outer_kept <= outer_kept_next;
      outer_seen <= outer_seen_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mean      <= mean_next;
    res_value <= res_value_next;
    res_flag  <= res_flag_next;
    if (load_out) begin
      filtered_value <= res_value;
      no_valid_data  <= res_flag;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/two_stage_rejecting_averager.sv */
// Two-stage rejecting averager. Each request on the input channel carries
// one 16-bit proximity sample. Samples of 32767 and above are counted but
// not averaged; every inner_count samples the truncated mean of the kept
// ones (0 if none) forms one inner average, and every outer_count inner
// averages the truncated mean of the nonzero ones is emitted as one output
// request, with no_valid_data set and filtered_value 0 when all of them
// were zero. The front accepts one sample per clock while its group queue
// (QUEUE_DEPTH entries) has room. The back divides each finished inner
// group that kept a sample, and each emitted result, on the shared
// serial divider, which produces one quotient bit per clock (23 steps);
// a result also waits for the output register to be taken. Both group
// counts reset to 10. Configuration is to be written through cfg_we /
// cfg_index / cfg_data only while the block is idle, which the block
// itself does not enforce; a write does not clear accumulated sums, and
// a count of 0 behaves like 1.
`timescale 1ns / 1ps
`default_nettype none

`include "two_stage_rejecting_averager_assert.svh"

module two_stage_rejecting_averager #(
  parameter int QUEUE_DEPTH = tsra_pkg::QUEUE_DEPTH
) (
  input  wire                           clk,
  input  wire                           rst,
  // Sample input channel.
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [tsra_pkg::SAMPLE_W-1:0]  sample,
  // Result output channel.
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [tsra_pkg::VALUE_W-1:0]  filtered_value,
  output logic                          no_valid_data,
  // Configuration write port.
  input  wire                           cfg_we,
  input  wire                           cfg_index,
  input  wire [tsra_pkg::COUNT_W-1:0]   cfg_data
);

  // Group counts, both resetting to ten.
  logic [tsra_pkg::COUNT_W-1:0] inner_count;
  logic [tsra_pkg::COUNT_W-1:0] outer_count;

  // Hand-off between the front and the queue, and the queue and the back.
  logic             q_push;
  tsra_pkg::group_t q_push_entry;
  logic             q_pop;
  tsra_pkg::group_t q_head;
  logic             q_not_empty;
  logic             q_not_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_count <= tsra_pkg::COUNT_RESET;
      outer_count <= tsra_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsra_pkg::REG_INNER_COUNT: inner_count <= cfg_data;
        tsra_pkg::REG_OUTER_COUNT: outer_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front sums accepted samples and pushes each finished inner group.
  tsra_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .inner_count (inner_count),
    .q_not_full  (q_not_full),
    .push        (q_push),
    .push_entry  (q_push_entry)
  );

  // The queue lets sampling continue while the back is dividing.
  tsra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .not_full   (q_not_full)
  );

  // The back forms inner means, runs the outer stage and holds the result
  // in an output register until it is taken.
  tsra_back u_back (
    .clk            (clk),
    .rst            (rst),
    .outer_count    (outer_count),
    .q_head         (q_head),
    .q_not_empty    (q_not_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .no_valid_data  (no_valid_data)
  );

  // A group is never pushed into a full queue.
  `TSRA_ASSERT_NEVER(a_push_into_full, q_push && !q_not_full)
  // An empty outer group always reports a zero value.
  `TSRA_ASSERT_IMPL(a_flag_means_zero, out_valid && no_valid_data, filtered_value == '0)
  // The back never pops an empty queue.
  `TSRA_ASSERT_NEVER(a_pop_from_empty, q_pop && !q_not_empty)
  // Reset leaves no result pending.
  `TSRA_ASSERT_NEXT(a_reset_clears_out, rst, !out_valid)

endmodule

`default_nettype wire
